/* rtl/core/mmp_pkg.sv */
// Shared types and constants for the MIDI message parser.
// Used by the interfaces, all core modules and the checker; depends on nothing.

package mmp_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int CHAN_W   = 4;
  localparam int DATA_W   = 7;
  localparam int AMOUNT_W = 14;
  localparam int NUM_KIND = 6;
  localparam int CNT_W    = 2;

  localparam logic [NUM_KIND-1:0] EVENT_ENABLE_RESET = 6'h3F;

  localparam logic [KIND_W-1:0] KIND_NOTE_OFF   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_ON    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POLY_AT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CTRL_CHG   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PROG_CHG   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PITCH_BEND = 3'd5;

  localparam logic [3:0] HI_PROG_CHG   = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
  localparam logic [3:0] HI_PITCH_BEND = 4'hE;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;

  localparam logic [BYTE_W-1:0] STATUS_SONG_POS = 8'hF2;
  localparam logic [BYTE_W-1:0] STATUS_SONG_SEL = 8'hF3;

  localparam logic [CNT_W-1:0] CNT_FIRST  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_SECOND = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   event_kind;
    logic [CHAN_W-1:0]   channel_number;
    logic [DATA_W-1:0]   key_or_number;
    logic [AMOUNT_W-1:0] amount;
  } evt_t;

  typedef struct packed {
    logic valid;
    evt_t evt;
  } dec_res_t;

  // Statuses that leave no message open: single-byte system and undefined.
  function automatic logic is_closing_system(input logic [BYTE_W-1:0] s);
    logic r;
    case (s)
      8'hF4, 8'hF5, 8'hF9, 8'hFD,
      8'hF6, 8'hF7, 8'hF8, 8'hFA,
      8'hFB, 8'hFC, 8'hFE, 8'hFF: r = 1'b1;
      default:                    r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/mmp_if.sv */
// Channel interfaces for the MIDI message parser: byte input, event output, config write.
// Depends on mmp_pkg.

interface mmp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [mmp_pkg::BYTE_W-1:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mmp_event_if;
  logic                         valid;
  logic                         ready;
  logic [mmp_pkg::KIND_W-1:0]   event_kind;
  logic [mmp_pkg::CHAN_W-1:0]   channel_number;
  logic [mmp_pkg::DATA_W-1:0]   key_or_number;
  logic [mmp_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, output event_kind, output channel_number,
                  output key_or_number, output amount, input ready);
  modport sink   (input valid, input event_kind, input channel_number,
                  input key_or_number, input amount, output ready);
endinterface

interface mmp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mmp_pkg::NUM_KIND-1:0] event_enable;

  modport source (output valid, output event_enable, input ready);
  modport sink   (input valid, input event_enable, output ready);
endinterface

/* rtl/core/midi_message_parser.sv */
// MIDI message parser top level: input byte register, enable register, decode, result register.
// Depends on mmp_pkg, mmp_if, mmp_decode and mmp_out_reg.
//
// Takes one raw MIDI byte per transfer and emits one event per completed note off, note on,
// poly aftertouch, control change, program change or pitch bend message whose bit is set in
// event_enable (reset 6'h3F). Running status is not supported. A byte is registered in the byte
// register, decoded combinationally against the parser state and its event, if any, lands in
// the result register, from which it is presented on the output channel. One byte is taken
// every cycle while the output side keeps up; the output register is the only thing that can
// stall input. The config channel is always ready and should be written only when the parser
// is idle.

module midi_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  mmp_byte_if.sink    in_ch,
  mmp_event_if.source out_ch,
  mmp_cfg_if.sink     cfg_ch
);
  import mmp_pkg::*;

  logic [BYTE_W-1:0]   byte_r;
  logic                byte_vld_r, byte_vld_nxt;
  logic [NUM_KIND-1:0] enable_r;
  logic                out_space;
  logic                fire;
  logic                in_xfer;
  dec_res_t            dec_res;

  assign fire        = byte_vld_r && out_space;
  assign in_ch.ready = !byte_vld_r || out_space;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (fire) begin
      byte_vld_nxt = 1'b0;
    end
    if (in_xfer) begin
      byte_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      enable_r   <= EVENT_ENABLE_RESET;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      if (cfg_ch.valid) begin
        enable_r <= cfg_ch.event_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_ch.midi_byte;
    end
  end

  mmp_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .byte_i   (byte_r),
    .enable_i (enable_r),
    .res_o    (dec_res)
  );

  mmp_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_i   (dec_res),
    .load    (fire),
    .space_o (out_space),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/core/mmp_decode.sv */
// Parser state and single-pass byte decode for the MIDI message parser.
// Depends on mmp_pkg.

module mmp_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [mmp_pkg::BYTE_W-1:0]   byte_i,
  input  logic [mmp_pkg::NUM_KIND-1:0] enable_i,
  output mmp_pkg::dec_res_t            res_o
);
  import mmp_pkg::*;

  logic [BYTE_W-1:0] status_r, status_nxt;
  logic              open_r, open_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic [DATA_W-1:0] first_r, first_nxt;

  logic [CNT_W-1:0]    cnt_inc;
  logic [3:0]          hi;
  logic                emit_req;
  logic [KIND_W-1:0]   kind;
  logic [DATA_W-1:0]   key;
  logic [AMOUNT_W-1:0] amt;

  assign hi      = status_r[7:4];
  assign cnt_inc = cnt_r + CNT_W'(1);

  always_comb begin
    status_nxt = status_r;
    open_nxt   = open_r;
    cnt_nxt    = cnt_r;
    chan_nxt   = chan_r;
    first_nxt  = first_r;
    emit_req   = 1'b0;
    kind       = KIND_NOTE_OFF;
    key        = '0;
    amt        = '0;
    if (fire) begin
      if (byte_i[7]) begin
        status_nxt = byte_i;
        chan_nxt   = (byte_i[7:4] == HI_SYSTEM) ? '0 : byte_i[3:0];
        cnt_nxt    = '0;
        open_nxt   = !is_closing_system(byte_i);
      end else if (open_r) begin
        cnt_nxt = cnt_inc;
        case (cnt_inc)
          CNT_FIRST: begin
            first_nxt = byte_i[DATA_W-1:0];
            if (status_r == STATUS_SONG_SEL || hi == HI_CHAN_PRESS) begin
              open_nxt = 1'b0;
            end else if (hi == HI_PROG_CHG) begin
              open_nxt = 1'b0;
              emit_req = 1'b1;
              kind     = KIND_PROG_CHG;
              key      = byte_i[DATA_W-1:0];
            end
          end
          CNT_SECOND: begin
            if (hi[3:2] == 2'b10) begin
              open_nxt = 1'b0;
              emit_req = 1'b1;
              kind     = {1'b0, hi[1:0]};
              key      = first_r;
              amt      = AMOUNT_W'(byte_i[DATA_W-1:0]);
            end else if (hi == HI_PITCH_BEND) begin
              open_nxt = 1'b0;
              emit_req = 1'b1;
              kind     = KIND_PITCH_BEND;
              amt      = {byte_i[DATA_W-1:0], first_r};
            end else if (status_r == STATUS_SONG_POS) begin
              open_nxt = 1'b0;
            end
          end
          default: begin
            open_nxt = 1'b0;
            cnt_nxt  = '0;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_o.valid              = emit_req && enable_i[kind];
    res_o.evt.event_kind     = kind;
    res_o.evt.channel_number = chan_r;
    res_o.evt.key_or_number  = key;
    res_o.evt.amount         = amt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      open_r   <= 1'b0;
      cnt_r    <= '0;
      chan_r   <= '0;
      first_r  <= '0;
    end else begin
      status_r <= status_nxt;
      open_r   <= open_nxt;
      cnt_r    <= cnt_nxt;
      chan_r   <= chan_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

/* rtl/core/mmp_out_reg.sv */
// Result register driving the event output channel.
// Depends on mmp_pkg and mmp_event_if.

module mmp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  mmp_pkg::dec_res_t res_i,
  input  logic              load,
  output logic              space_o,
  mmp_event_if.source       out_ch
);
  import mmp_pkg::*;

  logic vld_r, vld_nxt;
  evt_t evt_r;

  assign space_o = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
    if (load && res_i.valid) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_i.valid) begin
      evt_r <= res_i.evt;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.event_kind     = evt_r.event_kind;
  assign out_ch.channel_number = evt_r.channel_number;
  assign out_ch.key_or_number  = evt_r.key_or_number;
  assign out_ch.amount         = evt_r.amount;

endmodule

/* rtl/core/mmp_checker.sv */
// Port-level checks for the MIDI message parser, bound to the top level.
// Depends on mmp_pkg.

module mmp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mmp_pkg::KIND_W-1:0]   event_kind,
  input logic [mmp_pkg::CHAN_W-1:0]   channel_number,
  input logic [mmp_pkg::DATA_W-1:0]   key_or_number,
  input logic [mmp_pkg::AMOUNT_W-1:0] amount
);
  import mmp_pkg::*;

  // stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
      $stable(channel_number) && $stable(key_or_number) && $stable(amount))
    else $error("event changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (event_kind != 3'd6 && event_kind != 3'd7))
    else $error("undefined event kind");

  a_bend_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == KIND_PITCH_BEND |-> key_or_number == '0)
    else $error("pitch bend with nonzero key");

  a_prog_amount: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == KIND_PROG_CHG |-> amount == '0)
    else $error("program change with nonzero amount");

  // only pitch bend carries a 14-bit amount
  a_amount_7b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind != KIND_PITCH_BEND |-> amount[AMOUNT_W-1:DATA_W] == '0)
    else $error("7-bit amount overflow");

endmodule

bind midi_message_parser mmp_checker u_mmp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .event_kind     (out_ch.event_kind),
  .channel_number (out_ch.channel_number),
  .key_or_number  (out_ch.key_or_number),
  .amount         (out_ch.amount)
);

/* verif/testbench.sv */
// Self-checking testbench for midi_message_parser: byte stream in, channel events out.
// A directed table and random message streams are scored against an in-bench parser model.
// Depends on mmp_pkg, the mmp_if interfaces and the midi_message_parser RTL.
`timescale 1ns / 100ps

module testbench;
  import mmp_pkg::*;

  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_POLY_AT  = 4'hA;
  localparam logic [3:0] HI_CTRL_CHG = 4'hB;
  // system statuses with a low nibble above this close at once
  localparam logic [3:0] SYS_LAST_MULTI = 4'h3;

  localparam logic [BYTE_W-1:0] STATUS_SYSEX      = 8'hF0;
  localparam logic [BYTE_W-1:0] STATUS_TIMING_CLK = 8'hF8;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int PHASE_ITEMS    = 230;
  localparam int NUM_PHASES     = 5;
  localparam int MAX_PRINTS     = 50;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_ALTERNATE, RX_BURSTY} rx_mode_t;

  typedef struct {
    logic [BYTE_W-1:0] midi_byte;
    bit                typed;
    bit                yields;
    evt_t              want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mmp_byte_if  in_bus ();
  mmp_event_if out_bus ();
  mmp_cfg_if   cfg_bus ();

  midi_message_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  logic [NUM_KIND-1:0] enable_mask;
  logic [BYTE_W-1:0]   open_status;
  logic                msg_open;
  logic [2:0]          data_count;
  logic [CHAN_W-1:0]   held_chan;
  logic [DATA_W-1:0]   first_data;
  logic [DATA_W-1:0]   second_data;

  evt_t     pending_events[$];
  evt_t     head_evt;
  int       err_count   = 0;
  int       idle_cycles = 0;
  int       burst_left  = 0;
  int       sent_count  = 0;
  int       stall_cycle = 0;
  rx_mode_t stall_mode  = RX_FREE;

  dir_row_t dir_rows [27] = '{
    '{{HI_NOTE_ON, 4'h0},    0, 0, '0},
    '{8'h00,                 0, 0, '0},
    '{8'h7F,                 1, 1, '{KIND_NOTE_ON, 4'd0, 7'd0, 14'd127}},
    '{{HI_NOTE_OFF, 4'hF},   0, 0, '0},
    '{8'h7F,                 0, 0, '0},
    '{8'h00,                 1, 1, '{KIND_NOTE_OFF, 4'd15, 7'd127, 14'd0}},
    '{{HI_POLY_AT, 4'h5},    0, 0, '0},
    '{8'h3C,                 0, 0, '0},
    '{8'h40,                 0, 0, '0},
    '{{HI_CTRL_CHG, 4'h3},   0, 0, '0},
    '{8'h07,                 0, 0, '0},
    '{8'h64,                 0, 0, '0},
    '{{HI_PROG_CHG, 4'hA},   0, 0, '0},
    '{8'h7F,                 1, 1, '{KIND_PROG_CHG, 4'd10, 7'd127, 14'd0}},
    '{{HI_PITCH_BEND, 4'h0}, 0, 0, '0},
    '{8'h7F,                 0, 0, '0},
    '{8'h7F,                 1, 1, '{KIND_PITCH_BEND, 4'd0, 7'd0, 14'd16383}},
    '{{HI_CHAN_PRESS, 4'h2}, 0, 0, '0},
    '{8'h11,                 1, 0, '0},
    // clock byte abandons the open note, trailing data is ignored
    '{{HI_NOTE_ON, 4'h2},    0, 0, '0},
    '{8'h40,                 0, 0, '0},
    '{STATUS_TIMING_CLK,     1, 0, '0},
    '{8'h10,                 1, 0, '0},
    '{STATUS_SYSEX,          0, 0, '0},
    '{8'h01,                 1, 0, '0},
    '{8'h02,                 1, 0, '0},
    '{8'h03,                 1, 0, '0}
  };

  logic [NUM_KIND-1:0] phase_masks [NUM_PHASES];

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Advance the model by one accepted byte; returns 1 when an event is delivered.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output evt_t e);
    logic [3:0] hi;
    bit         fire;
    fire = 1'b0;
    e    = '0;
    if (b[7]) begin
      open_status = b;
      held_chan   = (b[7:4] == HI_SYSTEM) ? 4'd0 : b[3:0];
      data_count  = 3'd0;
      msg_open    = !((b[7:4] == HI_SYSTEM) && (b[3:0] > SYS_LAST_MULTI));
      return 1'b0;
    end
    if (!msg_open) return 1'b0;
    data_count = data_count + 3'd1;
    if (data_count == 3'd1) first_data = b[6:0];
    else if (data_count == 3'd2) second_data = b[6:0];
    hi = open_status[7:4];
    e.channel_number = held_chan;
    case (data_count)
      3'd1: begin
        if (open_status == STATUS_SONG_SEL || hi == HI_CHAN_PRESS) begin
          msg_open = 1'b0;
        end else if (hi == HI_PROG_CHG) begin
          msg_open        = 1'b0;
          fire            = 1'b1;
          e.event_kind    = KIND_PROG_CHG;
          e.key_or_number = first_data;
        end
      end
      3'd2: begin
        if (hi >= HI_NOTE_OFF && hi <= HI_CTRL_CHG) begin
          msg_open        = 1'b0;
          fire            = 1'b1;
          e.event_kind    = KIND_NOTE_OFF + KIND_W'(hi[1:0]);
          e.key_or_number = first_data;
          e.amount        = {7'd0, second_data};
        end else if (hi == HI_PITCH_BEND) begin
          msg_open     = 1'b0;
          fire         = 1'b1;
          e.event_kind = KIND_PITCH_BEND;
          e.amount     = {second_data, first_data};
        end else if (open_status == STATUS_SONG_POS) begin
          msg_open = 1'b0;
        end
      end
      default: begin
        msg_open   = 1'b0;
        data_count = 3'd0;
      end
    endcase
    return fire && enable_mask[e.event_kind];
  endfunction

  // Called and returns at a falling edge; valid stays high for a following byte.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                           input bit yields = 1'b0, input evt_t want = '0);
    evt_t e;
    int   gap;
    bit   fire;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_bus.valid     <= 1'b1;
    in_bus.midi_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    fire = parse_byte(b, e);
    if (typed) begin
      if (yields) pending_events.push_back(want);
    end else if (fire) begin
      pending_events.push_back(e);
    end
    burst_left--;
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] rand_data();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h7F;
      default: return BYTE_W'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_random_message();
    logic [BYTE_W-1:0] msg[$];
    logic [3:0]        hi;
    int unsigned       pick;
    int unsigned       n_data;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      hi = 4'($urandom_range(HI_NOTE_OFF, HI_PITCH_BEND));
      msg.push_back({hi, 4'($urandom_range(0, 15))});
      n_data = (hi == HI_PROG_CHG || hi == HI_CHAN_PRESS) ? 1 : 2;
      repeat (n_data) msg.push_back(rand_data());
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) == 0)
          msg.insert($urandom_range(1, msg.size() - 1), {HI_SYSTEM, 4'($urandom_range(8, 15))});
        else
          msg.insert($urandom_range(1, msg.size() - 1), BYTE_W'($urandom_range(128, 255)));
      end
      if ($urandom_range(0, 19) == 0) msg.delete(msg.size() - 1);
      if ($urandom_range(0, 9) == 0) msg.push_back(rand_data());
    end else if (pick < 88) begin
      msg.push_back({HI_SYSTEM, 4'($urandom_range(0, 15))});
      repeat ($urandom_range(0, 4)) msg.push_back(rand_data());
    end else begin
      repeat ($urandom_range(1, 3)) msg.push_back(BYTE_W'($urandom_range(0, 255)));
    end
    foreach (msg[i]) push_byte(msg[i]);
  endtask

  // Parser must be idle: wait out pending events plus bytes still in the pipeline.
  task automatic write_enable(input logic [NUM_KIND-1:0] m);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid        <= 1'b1;
    cfg_bus.event_enable <= m;
    do @(posedge clk); while (!cfg_bus.ready);
    enable_mask = m;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_cycle % 96 == 0) stall_mode = rx_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_FREE:      out_bus.ready <= 1'b1;
      RX_RANDOM:    out_bus.ready <= ($urandom_range(0, 3) != 0);
      RX_ALTERNATE: out_bus.ready <= stall_cycle[0];
      default:      out_bus.ready <= (stall_cycle[3:0] >= 4'd12);
    endcase
    stall_cycle++;
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d ch %0d",
                                  out_bus.event_kind, out_bus.channel_number));
      end else begin
        head_evt = pending_events.pop_front();
        if (out_bus.event_kind !== head_evt.event_kind)
          report_mismatch($sformatf("event_kind got %0d want %0d",
                                    out_bus.event_kind, head_evt.event_kind));
        if (out_bus.channel_number !== head_evt.channel_number)
          report_mismatch($sformatf("channel_number got %0d want %0d",
                                    out_bus.channel_number, head_evt.channel_number));
        if (out_bus.key_or_number !== head_evt.key_or_number)
          report_mismatch($sformatf("key_or_number got %0d want %0d",
                                    out_bus.key_or_number, head_evt.key_or_number));
        if (out_bus.amount !== head_evt.amount)
          report_mismatch($sformatf("amount got %0d want %0d",
                                    out_bus.amount, head_evt.amount));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("[midi_message_parser] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.midi_byte     = '0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.event_enable = '0;
    enable_mask          = EVENT_ENABLE_RESET;
    open_status          = '0;
    msg_open             = 1'b0;
    data_count           = '0;
    held_chan            = '0;
    first_data           = '0;
    second_data          = '0;
    phase_masks = '{6'h00, 6'h3F, 6'h15, 6'h2A, NUM_KIND'($urandom_range(0, 63))};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      push_byte(dir_rows[i].midi_byte, dir_rows[i].typed, dir_rows[i].yields, dir_rows[i].want);
    in_bus.valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_enable(phase_masks[p]);
      sent_count = 0;
      while (sent_count < PHASE_ITEMS) send_random_message();
      in_bus.valid <= 1'b0;
    end

    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("[midi_message_parser] OK");
    else
      $display("[midi_message_parser] ERROR");
    $finish;
  end

endmodule
